[hw/rtl/qte_pkg.sv]
// qte_pkg: shared widths, constants and stage types for the quaternion to
// Euler angle converter. Used by qte_sqrt_cell, qte_cordic_cell and the top.
// Depends on nothing.
package qte_pkg;

    localparam int IN_W          = 16;
    localparam int OUT_W         = 16;
    localparam int PROD_W        = 32;
    localparam int TEST_W        = 33;
    localparam int RAW_W         = 36;
    localparam int XY_W          = 56;
    localparam int Z_W           = 36;
    localparam int ROOT_W        = 31;
    localparam int REM_W         = 61;
    localparam int MAG_W         = 30;
    localparam int PRESCALE      = 16;
    localparam int Q12_SHIFT     = 18;
    localparam int ANG_TABLE_LEN = 24;

    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic signed [TEST_W-1:0] POLE_LIMIT  = 33'sd535797170;
    localparam logic signed [Z_W-1:0]    PI_Q30      = 36'sd3373259426;
    localparam logic signed [RAW_W-1:0]  ONE_Q30     = 36'sd1073741824;
    localparam logic signed [OUT_W-1:0]  HALF_PI_Q12 = 16'sd6434;
    localparam logic [REM_W-1:0]         ONE_Q60     = 61'h1000_0000_0000_0000;

    // atan(2^-i) in units of 2^-30 rad, truncated
    localparam logic signed [Z_W-1:0] ANG_TAB [ANG_TABLE_LEN] = '{
        36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158,
        36'sd67021686,  36'sd33543515,  36'sd16775850,  36'sd8388437,
        36'sd4194282,   36'sd2097149,   36'sd1048575,   36'sd524287,
        36'sd262143,    36'sd131071,    36'sd65535,     36'sd32767,
        36'sd16383,     36'sd8191,      36'sd4095,      36'sd2047,
        36'sd1023,      36'sd511,       36'sd255,       36'sd127
    };

    // raw products of the input components
    typedef struct packed {
        logic signed [IN_W-1:0]   qx;
        logic signed [IN_W-1:0]   qw;
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] zw;
        logic signed [PROD_W-1:0] yw;
        logic signed [PROD_W-1:0] xz;
        logic signed [PROD_W-1:0] xw;
        logic signed [PROD_W-1:0] yz;
    } prod_t;

    // atan2 operands and pole flags carried alongside the square root
    typedef struct packed {
        logic                    pole;
        logic                    pole_neg;
        logic signed [RAW_W-1:0] yaw_y;
        logic signed [RAW_W-1:0] yaw_x;
        logic signed [RAW_W-1:0] pitch_y;
        logic signed [RAW_W-1:0] pitch_x;
        logic signed [RAW_W-1:0] s_val;
    } side_t;

    typedef struct packed {
        side_t            side;
        logic [MAG_W-1:0] s_mag;
    } front_t;

    typedef struct packed {
        side_t             side;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic                   zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } lane_t;

    typedef struct packed {
        lane_t yaw;
        lane_t pitch;
        lane_t roll;
        logic  pole;
        logic  pole_neg;
    } cs_t;

endpackage

[hw/rtl/qte_sqrt_cell.sv]
// qte_sqrt_cell: one result bit of the restoring integer square root.
// Carries the side operands along unchanged. Depends on qte_pkg.
module qte_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           in_valid,
    input  qte_pkg::sq_t   in_data,
    output logic           out_valid,
    output qte_pkg::sq_t   out_data
);

    localparam logic [63:0] BIT_SQ = 64'd1 << (2 * BIT);
    localparam logic [qte_pkg::ROOT_W-1:0] BIT_ONE = qte_pkg::ROOT_W'(1) << BIT;

    logic           valid_reg;
    qte_pkg::sq_t   data_reg;
    qte_pkg::sq_t   data_next;
    logic [63:0]    trial;
    logic [63:0]    rem_wide;

    // try setting this root bit, keep it when the remainder allows
    always_comb
    begin
        trial     = (64'(in_data.root) << (BIT + 1)) + BIT_SQ;
        rem_wide  = 64'(in_data.rem);
        data_next = in_data;
        if (rem_wide >= trial)
        begin
            data_next.rem  = qte_pkg::REM_W'(rem_wide - trial);
            data_next.root = in_data.root | BIT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hw/rtl/qte_cordic_cell.sv]
// qte_cordic_cell: one vectoring CORDIC micro-rotation for the yaw, pitch
// and roll lanes. Depends on qte_pkg.
module qte_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          in_valid,
    input  qte_pkg::cs_t  in_data,
    output logic          out_valid,
    output qte_pkg::cs_t  out_data
);

    localparam logic signed [qte_pkg::Z_W-1:0] ANG = qte_pkg::ANG_TAB[STAGE];

    logic          valid_reg;
    qte_pkg::cs_t  data_reg;
    qte_pkg::cs_t  data_next;

    // rotate toward the x axis, accumulate the angle
    function automatic qte_pkg::lane_t rotate(input qte_pkg::lane_t l);
        logic signed [qte_pkg::XY_W-1:0] dx;
        logic signed [qte_pkg::XY_W-1:0] dy;
        qte_pkg::lane_t r;
        dx = l.y >>> STAGE;
        dy = l.x >>> STAGE;
        r  = l;
        if (l.y > 0)
        begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + ANG;
        end
        else
        begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - ANG;
        end
        return r;
    endfunction

    always_comb
    begin
        data_next       = in_data;
        data_next.yaw   = rotate(in_data.yaw);
        data_next.pitch = rotate(in_data.pitch);
        data_next.roll  = rotate(in_data.roll);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hw/rtl/quaternion_to_euler.sv]
// Quaternion to Euler angle converter: takes x, y, z, w in signed Q1.15 and
// returns pitch, yaw and roll in signed Q4.12 radians, with the pole cases
// (|xy+zw| > 0.499) giving roll = +-pi/2, pitch = 0 and yaw = +-2*atan2(x,w).
// The block is a fully pipelined chain: three front stages of products and
// operand set-up, 31 square-root cells for the asin term, one fold stage,
// CORDIC_STAGES CORDIC cells and an output register. A new transfer is
// taken every cycle; the whole chain holds only while a result sits on the
// output with out_stall high. No clearing is needed after reset.
// Depends on qte_pkg, qte_sqrt_cell and qte_cordic_cell.
module quaternion_to_euler #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [qte_pkg::IN_W-1:0] quat_x,
    input  logic signed [qte_pkg::IN_W-1:0] quat_y,
    input  logic signed [qte_pkg::IN_W-1:0] quat_z,
    input  logic signed [qte_pkg::IN_W-1:0] quat_w,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [qte_pkg::OUT_W-1:0] pitch_angle,
    output logic signed [qte_pkg::OUT_W-1:0] yaw_angle,
    output logic signed [qte_pkg::OUT_W-1:0] roll_angle
);

    localparam int ROOT_W = qte_pkg::ROOT_W;
    localparam int RAW_W  = qte_pkg::RAW_W;
    localparam int XY_W   = qte_pkg::XY_W;
    localparam int Z_W    = qte_pkg::Z_W;
    localparam int OUT_W  = qte_pkg::OUT_W;
    localparam int PROD_W = qte_pkg::PROD_W;
    localparam int SQ_W   = 2 * qte_pkg::MAG_W;
    localparam int V_W    = Z_W + 1;

    logic advance;

    logic            prod_valid_reg;
    qte_pkg::prod_t  prod_reg;
    qte_pkg::prod_t  prod_next;
    logic            front_valid_reg;
    qte_pkg::front_t front_reg;
    qte_pkg::front_t front_next;
    logic            sq_valid_reg;
    qte_pkg::sq_t    sq_reg;
    qte_pkg::sq_t    sq_next;

    logic            sq_v [0:ROOT_W];
    qte_pkg::sq_t    sq_d [0:ROOT_W];

    logic            fold_valid_reg;
    qte_pkg::cs_t    fold_reg;
    qte_pkg::cs_t    fold_next;

    logic            cs_v [0:CORDIC_STAGES];
    qte_pkg::cs_t    cs_d [0:CORDIC_STAGES];

    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  pitch_reg;
    logic signed [OUT_W-1:0]  yaw_reg;
    logic signed [OUT_W-1:0]  roll_reg;
    logic signed [OUT_W-1:0]  pitch_next;
    logic signed [OUT_W-1:0]  yaw_next;
    logic signed [OUT_W-1:0]  roll_next;

    logic signed [qte_pkg::TEST_W-1:0] test;
    logic signed [RAW_W-1:0]           s_wide;
    logic signed [RAW_W-1:0]           s_abs;
    logic [SQ_W-1:0]                   s_sq;

    // hold the whole chain while a finished result waits
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    // form the component products
    always_comb
    begin
        prod_next.qx = quat_x;
        prod_next.qw = quat_w;
        prod_next.xx = PROD_W'(quat_x) * PROD_W'(quat_x);
        prod_next.yy = PROD_W'(quat_y) * PROD_W'(quat_y);
        prod_next.zz = PROD_W'(quat_z) * PROD_W'(quat_z);
        prod_next.xy = PROD_W'(quat_x) * PROD_W'(quat_y);
        prod_next.zw = PROD_W'(quat_z) * PROD_W'(quat_w);
        prod_next.yw = PROD_W'(quat_y) * PROD_W'(quat_w);
        prod_next.xz = PROD_W'(quat_x) * PROD_W'(quat_z);
        prod_next.xw = PROD_W'(quat_x) * PROD_W'(quat_w);
        prod_next.yz = PROD_W'(quat_y) * PROD_W'(quat_z);
    end

    // set up the atan2 operands and the pole decision
    always_comb
    begin
        test   = qte_pkg::TEST_W'(prod_reg.xy) + qte_pkg::TEST_W'(prod_reg.zw);
        s_wide = RAW_W'(test) <<< 1;
        s_abs  = (s_wide < 0) ? -s_wide : s_wide;
        front_next.side.pole     = (test > qte_pkg::POLE_LIMIT) ||
                                   (test < -qte_pkg::POLE_LIMIT);
        front_next.side.pole_neg = (test < -qte_pkg::POLE_LIMIT);
        if (front_next.side.pole)
        begin
            front_next.side.yaw_y = RAW_W'(prod_reg.qx) <<< 15;
            front_next.side.yaw_x = RAW_W'(prod_reg.qw) <<< 15;
            front_next.s_mag      = '0;
        end
        else
        begin
            front_next.side.yaw_y = (RAW_W'(prod_reg.yw) - RAW_W'(prod_reg.xz)) <<< 1;
            front_next.side.yaw_x = qte_pkg::ONE_Q30 -
                ((RAW_W'(prod_reg.yy) + RAW_W'(prod_reg.zz)) <<< 1);
            front_next.s_mag      = s_abs[qte_pkg::MAG_W-1:0];
        end
        front_next.side.pitch_y = (RAW_W'(prod_reg.xw) - RAW_W'(prod_reg.yz)) <<< 1;
        front_next.side.pitch_x = qte_pkg::ONE_Q30 -
            ((RAW_W'(prod_reg.xx) + RAW_W'(prod_reg.zz)) <<< 1);
        front_next.side.s_val   = s_wide;
    end

    // radicand of the cosine term
    always_comb
    begin
        s_sq         = SQ_W'(front_reg.s_mag) * SQ_W'(front_reg.s_mag);
        sq_next.side = front_reg.side;
        sq_next.rem  = qte_pkg::ONE_Q60 - qte_pkg::REM_W'(s_sq);
        sq_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg  <= 1'b0;
            front_valid_reg <= 1'b0;
            sq_valid_reg    <= 1'b0;
            fold_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            prod_valid_reg  <= in_valid;
            front_valid_reg <= prod_valid_reg;
            sq_valid_reg    <= front_valid_reg;
            fold_valid_reg  <= sq_v[ROOT_W];
            out_valid_reg   <= cs_v[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg  <= prod_next;
            front_reg <= front_next;
            sq_reg    <= sq_next;
            fold_reg  <= fold_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            roll_reg  <= roll_next;
        end
    end

    // square root chain, most significant bit first
    assign sq_v[0] = sq_valid_reg;
    assign sq_d[0] = sq_reg;

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_sqrt
            qte_sqrt_cell #(
                .BIT (ROOT_W - 1 - k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .in_valid  (sq_v[k]),
                .in_data   (sq_d[k]),
                .out_valid (sq_v[k+1]),
                .out_data  (sq_d[k+1])
            );
        end
    endgenerate

    // fold the left half plane, flag the zero vector, prescale
    function automatic qte_pkg::lane_t fold(input logic signed [RAW_W-1:0] yv,
                                            input logic signed [RAW_W-1:0] xv);
        qte_pkg::lane_t l;
        logic signed [RAW_W-1:0] xn;
        logic signed [RAW_W-1:0] yn;
        l.zero = (xv == 0) && (yv == 0);
        if (xv < 0)
        begin
            xn  = -xv;
            yn  = -yv;
            l.z = (yv >= 0) ? qte_pkg::PI_Q30 : -qte_pkg::PI_Q30;
        end
        else
        begin
            xn  = xv;
            yn  = yv;
            l.z = '0;
        end
        l.x = XY_W'(xn) <<< qte_pkg::PRESCALE;
        l.y = XY_W'(yn) <<< qte_pkg::PRESCALE;
        return l;
    endfunction

    always_comb
    begin
        fold_next.yaw      = fold(sq_d[ROOT_W].side.yaw_y, sq_d[ROOT_W].side.yaw_x);
        fold_next.pitch    = fold(sq_d[ROOT_W].side.pitch_y, sq_d[ROOT_W].side.pitch_x);
        fold_next.roll     = fold(sq_d[ROOT_W].side.s_val,
                                  signed'(RAW_W'(sq_d[ROOT_W].root)));
        fold_next.pole     = sq_d[ROOT_W].side.pole;
        fold_next.pole_neg = sq_d[ROOT_W].side.pole_neg;
    end

    // CORDIC chain
    assign cs_v[0] = fold_valid_reg;
    assign cs_d[0] = fold_reg;

    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_cordic
            qte_cordic_cell #(
                .STAGE (i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .in_valid  (cs_v[i]),
                .in_data   (cs_d[i]),
                .out_valid (cs_v[i+1]),
                .out_data  (cs_d[i+1])
            );
        end
    endgenerate

    // round half up to Q4.12
    function automatic logic signed [OUT_W-1:0] to_q12(input logic signed [V_W-1:0] v);
        logic signed [V_W-1:0] r;
        r = (v + (V_W'(1) <<< (qte_pkg::Q12_SHIFT - 1))) >>> qte_pkg::Q12_SHIFT;
        return r[OUT_W-1:0];
    endfunction

    function automatic logic signed [V_W-1:0] angle(input qte_pkg::lane_t l);
        return l.zero ? '0 : V_W'(l.z);
    endfunction

    // pick pole or regular results
    always_comb
    begin
        if (cs_d[CORDIC_STAGES].pole)
        begin
            pitch_next = '0;
            if (cs_d[CORDIC_STAGES].pole_neg)
            begin
                yaw_next  = to_q12(-(angle(cs_d[CORDIC_STAGES].yaw) <<< 1));
                roll_next = -qte_pkg::HALF_PI_Q12;
            end
            else
            begin
                yaw_next  = to_q12(angle(cs_d[CORDIC_STAGES].yaw) <<< 1);
                roll_next = qte_pkg::HALF_PI_Q12;
            end
        end
        else
        begin
            pitch_next = to_q12(angle(cs_d[CORDIC_STAGES].pitch));
            yaw_next   = to_q12(angle(cs_d[CORDIC_STAGES].yaw));
            roll_next  = to_q12(angle(cs_d[CORDIC_STAGES].roll));
        end
    end

    assign out_valid   = out_valid_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;
    assign roll_angle  = roll_reg;

    // an accepted transfer enters the product stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> prod_valid_reg)
        else $error("accepted transfer not captured");

    // a held chain keeps its last CORDIC item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance && cs_v[CORDIC_STAGES] |=> cs_v[CORDIC_STAGES])
        else $error("item lost while chain held");

    // a new result comes from the last CORDIC cell
    a_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cs_v[CORDIC_STAGES]))
        else $error("result without source item");

endmodule
